### rtl/core/slt_pkg.sv
// Package for the sorted list table: command, status and sequencer state types
// and the fixed field widths. No dependencies; the core, the checker and the
// testbench refer to it by scoped names (slt_ram does not use it).
`default_nettype none

package slt_pkg;

    // Fixed widths of the item fields.
    localparam int VALUE_W     = 32;
    localparam int CMD_W       = 2;
    localparam int INDEX_W     = 4;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;

    // Command codes carried on the command field.
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2
    } t_cmd;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE      = 3'd0,
        S_INS_SCAN  = 3'd1,
        S_INS_HEAD  = 3'd2,
        S_DEL_FIND  = 3'd3,
        S_DEL_SHIFT = 3'd4,
        S_RD_WAIT   = 3'd5,
        S_DONE      = 3'd6
    } t_state;

endpackage

`default_nettype wire

### rtl/core/sorted_list_table_core.sv
// Sorted list table: one command at a time, one table entry per cycle. An insert
// scans down past the entries greater than the value, a delete scans up from the
// head; an empty or full table, a bad read index or an unused code finish without
// a scan. The next transfer is taken in the cycle after the result loads; a
// finished command waits while the last result is held.
// Reset (synchronous, active low) empties the table and drops any held result.
`default_nettype none

module sorted_list_table_core #(
    parameter int CAPACITY = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Command channel.
    input  wire logic                           i_valid,
    output      logic                           o_ready,
    input  wire logic [slt_pkg::CMD_W-1:0]      i_cmd,
    input  wire logic signed [slt_pkg::VALUE_W-1:0] i_value,
    input  wire logic [slt_pkg::INDEX_W-1:0]    i_index,
    // Result channel.
    output      logic                           o_valid,
    input  wire logic                           i_ready,
    output      logic [slt_pkg::STATUS_W-1:0]   o_status,
    output      logic signed [slt_pkg::VALUE_W-1:0] o_read_value,
    output      logic [slt_pkg::COUNT_OUT_W-1:0] o_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > slt_pkg::INDEX_W) ? CW : slt_pkg::INDEX_W;

    slt_pkg::t_state  r_state, n_state;
    logic [AW-1:0]    r_ptr, n_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic signed [slt_pkg::VALUE_W-1:0] r_val, n_val;
    slt_pkg::t_status r_status, n_status;
    logic signed [slt_pkg::VALUE_W-1:0] r_rdata, n_rdata;

    logic                               r_out_valid;
    slt_pkg::t_status                   r_out_status;
    logic signed [slt_pkg::VALUE_W-1:0] r_out_read_value;
    logic [slt_pkg::COUNT_OUT_W-1:0]    r_out_count;

    logic                               mem_we;
    logic [AW-1:0]                      mem_waddr;
    logic [slt_pkg::VALUE_W-1:0]        mem_wdata;
    logic [AW-1:0]                      mem_raddr;
    logic signed [slt_pkg::VALUE_W-1:0] mem_rdata;

    logic in_xfer;
    logic out_load;
    logic is_full;
    logic is_empty;
    logic at_last;
    logic cmp_gt;
    logic cmp_eq;
    logic idx_ok;

    // Entry storage.
    slt_ram #(
        .WIDTH (slt_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Shared compare unit and conditions on the count and pointer.
    assign in_xfer  = i_valid && o_ready;
    assign out_load = (r_state == slt_pkg::S_DONE) && (!r_out_valid || i_ready);
    assign is_full  = (r_count == CW'(CAPACITY));
    assign is_empty = (r_count == '0);
    assign at_last  = (CW'(r_ptr) == (r_count - CW'(1)));
    assign cmp_gt   = (mem_rdata > r_val);
    assign cmp_eq   = (mem_rdata == r_val);
    assign idx_ok   = (XW'(i_index) < XW'(r_count));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            slt_pkg::S_IDLE: begin
                if (in_xfer) begin
                    case (slt_pkg::t_cmd'(i_cmd))
                        slt_pkg::CMD_INSERT: begin
                            if (is_full || is_empty) begin
                                n_state = slt_pkg::S_DONE;
                            end else begin
                                n_state = slt_pkg::S_INS_SCAN;
                            end
                        end
                        slt_pkg::CMD_DELETE: begin
                            n_state = is_empty ? slt_pkg::S_DONE : slt_pkg::S_DEL_FIND;
                        end
                        slt_pkg::CMD_READ: begin
                            n_state = idx_ok ? slt_pkg::S_RD_WAIT : slt_pkg::S_DONE;
                        end
                        default: begin
                            n_state = slt_pkg::S_DONE;
                        end
                    endcase
                end
            end
            slt_pkg::S_INS_SCAN: begin
                if (!cmp_gt) begin
                    n_state = slt_pkg::S_DONE;
                end else if (r_ptr == '0) begin
                    n_state = slt_pkg::S_INS_HEAD;
                end
            end
            slt_pkg::S_INS_HEAD: begin
                n_state = slt_pkg::S_DONE;
            end
            slt_pkg::S_DEL_FIND: begin
                if (cmp_eq) begin
                    n_state = at_last ? slt_pkg::S_DONE : slt_pkg::S_DEL_SHIFT;
                end else if (at_last) begin
                    n_state = slt_pkg::S_DONE;
                end
            end
            slt_pkg::S_DEL_SHIFT: begin
                if (at_last) begin
                    n_state = slt_pkg::S_DONE;
                end
            end
            slt_pkg::S_RD_WAIT: begin
                n_state = slt_pkg::S_DONE;
            end
            slt_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = slt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = slt_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath control: RAM ports, pointer, count and result fields.
    always_comb begin
        n_ptr     = r_ptr;
        n_count   = r_count;
        n_val     = r_val;
        n_status  = r_status;
        n_rdata   = r_rdata;
        mem_we    = 1'b0;
        mem_waddr = r_ptr;
        mem_wdata = r_val;
        mem_raddr = r_ptr;
        case (r_state)
            slt_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_val    = i_value;
                    n_status = slt_pkg::ST_OK;
                    n_rdata  = '0;
                    case (slt_pkg::t_cmd'(i_cmd))
                        slt_pkg::CMD_INSERT: begin
                            if (is_full) begin
                                n_status = slt_pkg::ST_FULL;
                            end else if (is_empty) begin
                                // First entry goes straight to the head.
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = i_value;
                                n_count   = r_count + CW'(1);
                            end else begin
                                // Scan downward from the last entry.
                                n_ptr     = AW'(r_count - CW'(1));
                                mem_raddr = AW'(r_count - CW'(1));
                            end
                        end
                        slt_pkg::CMD_DELETE: begin
                            if (is_empty) begin
                                n_status = slt_pkg::ST_NOT_FOUND;
                            end else begin
                                n_ptr     = '0;
                                mem_raddr = '0;
                            end
                        end
                        slt_pkg::CMD_READ: begin
                            if (idx_ok) begin
                                mem_raddr = AW'(i_index);
                            end else begin
                                n_status = slt_pkg::ST_RANGE;
                            end
                        end
                        default: begin
                            n_status = slt_pkg::ST_OK;
                        end
                    endcase
                end
            end
            slt_pkg::S_INS_SCAN: begin
                // Greater entries move up one place; the value lands above
                // the first entry that is not greater.
                mem_we    = 1'b1;
                mem_waddr = r_ptr + AW'(1);
                if (cmp_gt) begin
                    mem_wdata = mem_rdata;
                    if (r_ptr != '0) begin
                        n_ptr     = r_ptr - AW'(1);
                        mem_raddr = r_ptr - AW'(1);
                    end
                end else begin
                    mem_wdata = r_val;
                    n_count   = r_count + CW'(1);
                end
            end
            slt_pkg::S_INS_HEAD: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = r_val;
                n_count   = r_count + CW'(1);
            end
            slt_pkg::S_DEL_FIND: begin
                if (cmp_eq && at_last) begin
                    n_count = r_count - CW'(1);
                end else if (!cmp_eq && at_last) begin
                    n_status = slt_pkg::ST_NOT_FOUND;
                end else begin
                    n_ptr     = r_ptr + AW'(1);
                    mem_raddr = r_ptr + AW'(1);
                end
            end
            slt_pkg::S_DEL_SHIFT: begin
                // Close the gap: each later entry moves down one place.
                mem_we    = 1'b1;
                mem_waddr = r_ptr - AW'(1);
                mem_wdata = mem_rdata;
                if (at_last) begin
                    n_count = r_count - CW'(1);
                end else begin
                    n_ptr     = r_ptr + AW'(1);
                    mem_raddr = r_ptr + AW'(1);
                end
            end
            slt_pkg::S_RD_WAIT: begin
                n_rdata = mem_rdata;
            end
            default: begin
                n_ptr = r_ptr;
            end
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slt_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_ptr    <= n_ptr;
        r_val    <= n_val;
        r_status <= n_status;
        r_rdata  <= n_rdata;
    end

    // Result register: holds a finished result until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out_status     <= r_status;
            r_out_read_value <= r_rdata;
            r_out_count      <= slt_pkg::COUNT_OUT_W'(r_count);
        end
    end

    assign o_ready      = (r_state == slt_pkg::S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_read_value = r_out_read_value;
    assign o_count      = r_out_count;

endmodule

`default_nettype wire

### rtl/core/slt_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`default_nettype none

module slt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/slt_checker.sv
// Port-level checker for the sorted list table, bound to
// sorted_list_table_core. Depends on slt_pkg.
`default_nettype none

module slt_checker #(
    parameter int CAPACITY = 16
) (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_valid,
    input wire logic                                o_ready,
    input wire logic                                o_valid,
    input wire logic                                i_ready,
    input wire logic [slt_pkg::STATUS_W-1:0]        o_status,
    input wire logic signed [slt_pkg::VALUE_W-1:0]  o_read_value,
    input wire logic [slt_pkg::COUNT_OUT_W-1:0]     o_count
);

    // A held result stays put until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status)
            && $stable(o_read_value) && $stable(o_count))
        else $error("result changed while stalled");

    // A command transfer makes the block busy in the next cycle.
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("command channel still ready after a transfer");

    // A failed read returns zero, and the count never passes the capacity.
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == slt_pkg::ST_RANGE) |-> (o_read_value == '0))
        else $error("out-of-range read returned a nonzero value");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (CAPACITY > 31) || (int'(o_count) <= CAPACITY))
        else $error("count exceeds capacity");

    // Reset drops any held result.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind sorted_list_table_core slt_checker #(
    .CAPACITY (CAPACITY)
) u_slt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_status     (o_status),
    .o_read_value (o_read_value),
    .o_count      (o_count)
);

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_list_table_core: directed table of commands,
// then biased random insert/delete/read traffic under several idling phases.
// Depends on slt_pkg and the core RTL only; results are checked against a local model.

module tb_top;

    localparam int SLT_CAPACITY = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1650;
    localparam int DRAIN_CYCLES = 2 * SLT_CAPACITY + 8;
    localparam int MAX_REPORTS  = 10;
    // Command code that the block treats as a no-op.
    localparam logic [slt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // One result as the block reports it.
    typedef struct packed {
        logic [slt_pkg::STATUS_W-1:0]       status;
        logic signed [slt_pkg::VALUE_W-1:0] read_value;
        logic [slt_pkg::COUNT_OUT_W-1:0]    count;
    } t_table_result;

    // One command, optionally with its expected result typed in.
    typedef struct {
        logic [slt_pkg::CMD_W-1:0]          cmd;
        logic signed [slt_pkg::VALUE_W-1:0] value;
        logic [slt_pkg::INDEX_W-1:0]        index;
        bit                                 typed;
        t_table_result                      res;
    } t_table_cmd;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_valid;
    logic                               o_ready;
    logic [slt_pkg::CMD_W-1:0]          i_cmd;
    logic signed [slt_pkg::VALUE_W-1:0] i_value;
    logic [slt_pkg::INDEX_W-1:0]        i_index;
    logic                               o_valid;
    logic                               i_ready;
    logic [slt_pkg::STATUS_W-1:0]       o_status;
    logic signed [slt_pkg::VALUE_W-1:0] o_read_value;
    logic [slt_pkg::COUNT_OUT_W-1:0]    o_count;

    // Local copy of the sorted table.
    logic signed [slt_pkg::VALUE_W-1:0] model_entries [SLT_CAPACITY];
    int                                 model_count;

    t_table_result pending_results [$];
    t_table_cmd    directed_rows [$];

    int sender_idle_pct;
    int receiver_stall_pct;
    int cycle_count;
    int mismatch_count;
    int result_count;
    int cmds_sent;
    int full_refusals;
    int absent_deletes;
    int range_reads;
    int max_fill_seen;

    sorted_list_table_core #(
        .CAPACITY(SLT_CAPACITY)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_value      (i_value),
        .i_index      (i_index),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_count      (o_count)
    );

    // Clock generation, 10 ns period.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit guard.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Apply one command to the local table and work out its result.
    task automatic table_apply(input t_table_cmd c, output t_table_result r);
        int pos;
        int i;
        r.status     = slt_pkg::ST_OK;
        r.read_value = '0;
        case (c.cmd)
            slt_pkg::CMD_INSERT: begin
                if (model_count >= SLT_CAPACITY) begin
                    r.status = slt_pkg::ST_FULL;
                    full_refusals++;
                end else begin
                    pos = model_count;
                    for (i = 0; i < model_count; i++) begin
                        if (model_entries[i] > c.value) begin
                            pos = i;
                            break;
                        end
                    end
                    for (i = model_count; i > pos; i--)
                        model_entries[i] = model_entries[i-1];
                    model_entries[pos] = c.value;
                    model_count++;
                end
            end
            slt_pkg::CMD_DELETE: begin
                pos = model_count;
                for (i = 0; i < model_count; i++) begin
                    if (model_entries[i] == c.value) begin
                        pos = i;
                        break;
                    end
                end
                if (pos == model_count) begin
                    r.status = slt_pkg::ST_NOT_FOUND;
                    absent_deletes++;
                end else begin
                    for (i = pos; i + 1 < model_count; i++)
                        model_entries[i] = model_entries[i+1];
                    model_count--;
                end
            end
            slt_pkg::CMD_READ: begin
                if (int'(c.index) < model_count) begin
                    r.read_value = model_entries[c.index];
                end else begin
                    r.status = slt_pkg::ST_RANGE;
                    range_reads++;
                end
            end
            default: ;
        endcase
        r.count = model_count[slt_pkg::COUNT_OUT_W-1:0];
        if (model_count > max_fill_seen)
            max_fill_seen = model_count;
    endtask

    // Present one command, wait for its transfer, then record what must come back.
    task automatic send_cmd(input t_table_cmd c);
        t_table_result predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= c.cmd;
        i_value <= c.value;
        i_index <= c.index;
        @(posedge i_clk);
        while (o_ready !== 1'b1)
            @(posedge i_clk);
        table_apply(c, predicted);
        if (c.typed)
            pending_results.push_back(c.res);
        else
            pending_results.push_back(predicted);
        cmds_sent++;
    endtask

    // Hold the command channel off until every pending result has arrived.
    task automatic hold_until_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic add_row(input logic [slt_pkg::CMD_W-1:0] cmd,
                           input logic signed [slt_pkg::VALUE_W-1:0] value,
                           input logic [slt_pkg::INDEX_W-1:0] index, input bit typed,
                           input logic [slt_pkg::STATUS_W-1:0] st,
                           input logic signed [slt_pkg::VALUE_W-1:0] rv,
                           input logic [slt_pkg::COUNT_OUT_W-1:0] cnt);
        t_table_cmd row;
        row.cmd            = cmd;
        row.value          = value;
        row.index          = index;
        row.typed          = typed;
        row.res.status     = st;
        row.res.read_value = rv;
        row.res.count      = cnt;
        directed_rows.push_back(row);
    endtask

    // Value mix: mostly a small pool so duplicates and hits happen, plus extremes.
    function automatic logic signed [slt_pkg::VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)
            return $signed($urandom_range(15)) - 8;
        else if (sel < 75) begin
            case ($urandom_range(5))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return 32'sh0000_0000;
                3: return -32'sd1;
                4: return 32'sh8000_0001;
                default: return 32'sh7FFF_FFFE;
            endcase
        end
        return $urandom();
    endfunction

    // Result checker and receiver back-pressure.
    always @(posedge i_clk) begin
        t_table_result want;
        if (i_rst_n && i_ready === 1'b1 && o_valid === 1'b1) begin
            result_count++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("Unexpected result: status=%0d value=%0d count=%0d",
                             o_status, o_read_value, o_count);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_read_value !== want.read_value ||
                    o_count !== want.count) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("Mismatch at result %0d: expected status=%0d value=%0d count=%0d",
                                 result_count, want.status, want.read_value, want.count);
                        $display("    got status=%0d value=%0d count=%0d",
                                 o_status, o_read_value, o_count);
                    end
                end
            end
        end
        i_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Stimulus: reset, directed table, random phases, drain and verdict.
    initial begin
        t_table_cmd c;
        int phase;
        int sent;
        int mode;
        int sel;
        int k;

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        mismatch_count     = 0;
        result_count       = 0;
        cmds_sent          = 0;
        full_refusals      = 0;
        absent_deletes     = 0;
        range_reads        = 0;
        max_fill_seen      = 0;
        model_count        = 0;
        for (k = 0; k < SLT_CAPACITY; k++)
            model_entries[k] = '0;

        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_ready <= 1'b0;
        i_cmd   <= slt_pkg::CMD_INSERT;
        i_value <= '0;
        i_index <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty-table cases and the two extremes, typed in where obvious.
        add_row(slt_pkg::CMD_READ,   0,  0,  1, slt_pkg::ST_RANGE,     0, 0);
        add_row(slt_pkg::CMD_DELETE, 5,  0,  1, slt_pkg::ST_NOT_FOUND, 0, 0);
        add_row(CMD_UNUSED, -32'sd1, 15, 1, slt_pkg::ST_OK, 0, 0);
        add_row(slt_pkg::CMD_INSERT, 32'sh7FFF_FFFF, 0, 1, slt_pkg::ST_OK, 0, 1);
        add_row(slt_pkg::CMD_INSERT, 32'sh8000_0000, 0, 1, slt_pkg::ST_OK, 0, 2);
        add_row(slt_pkg::CMD_READ, 0, 0,  1, slt_pkg::ST_OK, 32'sh8000_0000, 2);
        add_row(slt_pkg::CMD_READ, 0, 1,  1, slt_pkg::ST_OK, 32'sh7FFF_FFFF, 2);
        add_row(slt_pkg::CMD_READ, 0, 15, 1, slt_pkg::ST_RANGE, 0, 2);
        // Duplicates, then delete of the first match and of the smallest.
        add_row(slt_pkg::CMD_INSERT, -32'sd1, 0, 0, slt_pkg::ST_OK, 0, 0);
        add_row(slt_pkg::CMD_INSERT, -32'sd1, 0, 0, slt_pkg::ST_OK, 0, 0);
        add_row(slt_pkg::CMD_DELETE, -32'sd1, 0, 0, slt_pkg::ST_OK, 0, 0);
        add_row(slt_pkg::CMD_DELETE, 32'sh8000_0000, 0, 0, slt_pkg::ST_OK, 0, 0);
        // Fill with descending values, each one twice, so inserts shift most of the table.
        for (k = 0; k < 14; k++)
            add_row(slt_pkg::CMD_INSERT, 100 - 10 * (k >> 1), 0, 0, slt_pkg::ST_OK, 0, 0);
        add_row(slt_pkg::CMD_INSERT, 0, 0,  1, slt_pkg::ST_FULL, 0, 16);
        add_row(slt_pkg::CMD_READ,   0, 15, 1, slt_pkg::ST_OK, 32'sh7FFF_FFFF, 16);
        add_row(slt_pkg::CMD_DELETE, 32'sh7FFF_FFFF, 0, 0, slt_pkg::ST_OK, 0, 0);

        sender_idle_pct    = 10;
        receiver_stall_pct = 10;
        foreach (directed_rows[k])
            send_cmd(directed_rows[k]);
        hold_until_drained();

        // Random traffic in four idling phases; the table is pushed between full and empty.
        sent = 0;
        mode = 0;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 59; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 59; end
                default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
            endcase
            while (sent < RANDOM_ITEMS * (phase + 1) / 4) begin
                if (sent % 50 == 0)
                    mode = $urandom_range(2);
                c.typed = 0;
                c.res   = '0;
                c.value = $urandom();
                c.index = $urandom_range(15);
                sel = $urandom_range(99);
                if (sel < 3) begin
                    c.cmd = CMD_UNUSED;
                end else begin
                    sel = $urandom_range(99);
                    if ((mode == 0 && sel < 70) || (mode == 1 && sel < 15) ||
                        (mode == 2 && sel < 40)) begin
                        c.cmd   = slt_pkg::CMD_INSERT;
                        c.value = pick_value();
                    end else if ((mode == 0 && sel < 85) || (mode == 1 && sel < 85) ||
                                 (mode == 2 && sel < 70)) begin
                        c.cmd = slt_pkg::CMD_DELETE;
                        if (model_count > 0 && $urandom_range(99) < 65)
                            c.value = model_entries[$urandom_range(model_count - 1)];
                        else
                            c.value = pick_value();
                    end else begin
                        c.cmd = slt_pkg::CMD_READ;
                    end
                end
                send_cmd(c);
                sent++;
                if ($urandom_range(99) == 0)
                    hold_until_drained();
            end
            hold_until_drained();
        end

        // Let any stray result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            mismatch_count++;
        if (mismatch_count > MAX_REPORTS)
            $display("%0d further mismatches were counted but not shown",
                     mismatch_count - MAX_REPORTS);
        $display("Ran %0d commands, %0d results checked, table filled up to %0d entries.",
                 cmds_sent, result_count, max_fill_seen);
        $display("Seen: %0d full inserts, %0d absent deletes, %0d reads past the count.",
                 full_refusals, absent_deletes, range_reads);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/core/slt_pkg.sv
rtl/core/slt_ram.sv
rtl/core/sorted_list_table_core.sv
rtl/core/slt_checker.sv
test/tb_top.sv
